// File: hw/rtl/masked_aes_sbox_macros.svh
// assertion macros for the masked sbox checker
`ifndef MASKED_AES_SBOX_MACROS_SVH
`define MASKED_AES_SBOX_MACROS_SVH

// assert that an implication holds at every clock edge outside reset
`define MAS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// assert that the consequence holds in the cycle after the antecedent
`define MAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/mas_pkg.sv
// package with types and gf(2^8) functions of the masked sbox
package mas_pkg;

  localparam logic [7:0] AffConst = 8'h63;

  typedef struct packed {
    logic [63:0] rand_high;
    logic [63:0] rand_low;
    logic [7:0]  share_in2;
    logic [7:0]  share_in1;
    logic [7:0]  share_in0;
  } sbox_in_t;

  typedef struct packed {
    logic [7:0] share_out2;
    logic [7:0] share_out1;
    logic [7:0] share_out0;
  } sbox_out_t;

  // aes field multiply, eight shift-and-add steps on bytes
  function automatic logic [7:0] gf_mul(input logic [7:0] p, input logic [7:0] q);
    logic [7:0] acc;
    logic [7:0] a;
    acc = 8'h00;
    a = p;
    for (int k = 0; k < 8; k++) begin
      if (q[k]) acc = acc ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  // squaring is linear; computed here as a field multiply of v by itself
  function automatic logic [7:0] gf_sq(input logic [7:0] v);
    return gf_mul(v, v);
  endfunction

  function automatic logic [7:0] gf_p4(input logic [7:0] v);
    return gf_sq(gf_sq(v));
  endfunction

  function automatic logic [7:0] gf_p16(input logic [7:0] v);
    return gf_p4(gf_p4(v));
  endfunction

  function automatic logic [7:0] aff_map(input logic [7:0] v);
    return v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
      ^ {v[3:0], v[7:4]} ^ AffConst;
  endfunction

endpackage

// File: hw/rtl/masked_aes_sbox.sv
// top level of the pipelined masked aes sbox
// Masked AES S-box, pipelined: one transaction is accepted in every cycle
// (busy_o is tied low) and its result appears on result_o with done_o high
// once it has passed the register stages described next. The first
// register stage latches the input, the next four each hold one masked
// field multiplication with its linear parts (squarings, refreshes), and
// the last holds the share-wise affine map. The receiver cannot stall:
// each result is shown for exactly one cycle and must be taken then.
// Shares are never recombined. With MASK_ORDER = 1 share_in2 is ignored
// and share_out2 is zero.
module masked_aes_sbox #(
  parameter int unsigned MASK_ORDER = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  mas_pkg::sbox_in_t operand_i,
  output logic              done_o,
  output mas_pkg::sbox_out_t result_o
);

  localparam int unsigned Nsh = MASK_ORDER + 1;
  localparam int unsigned NumStages = 6;

  typedef logic [Nsh-1:0][7:0] shares_t;
  typedef logic [15:0][7:0] rand_t;

  // random byte offsets in consumption order
  localparam int unsigned PairCnt = Nsh * (Nsh - 1) / 2;
  localparam int unsigned RzOff = 0;
  localparam int unsigned M1Off = RzOff + MASK_ORDER;
  localparam int unsigned RwOff = M1Off + PairCnt;
  localparam int unsigned M2Off = RwOff + MASK_ORDER;
  localparam int unsigned M3Off = M2Off + PairCnt;
  localparam int unsigned M4Off = M3Off + PairCnt;

  // isw multiplication, pair randomness taken from rnd at offset off
  function automatic shares_t isw(input shares_t a, input shares_t b,
                                  input rand_t rnd, input int unsigned off);
    logic [Nsh-1:0][Nsh-1:0][7:0] r;
    shares_t c;
    int unsigned idx;
    r = '0;
    idx = off;
    for (int i = 0; i < Nsh; i++) begin
      for (int j = i + 1; j < Nsh; j++) begin
        r[i][j] = rnd[idx[3:0]];
        r[j][i] = rnd[idx[3:0]] ^ mas_pkg::gf_mul(a[i], b[j])
          ^ mas_pkg::gf_mul(a[j], b[i]);
        idx++;
      end
    end
    for (int i = 0; i < Nsh; i++) begin
      c[i] = mas_pkg::gf_mul(a[i], b[i]);
      for (int j = 0; j < Nsh; j++) begin
        if (j != i) c[i] = c[i] ^ r[i][j];
      end
    end
    return c;
  endfunction

  function automatic shares_t refresh(input shares_t x, input rand_t rnd,
                                      input int unsigned off);
    shares_t y;
    int unsigned idx;
    y = x;
    idx = off;
    for (int i = 1; i < Nsh; i++) begin
      y[0] = y[0] ^ rnd[idx[3:0]];
      y[i] = y[i] ^ rnd[idx[3:0]];
      idx++;
    end
    return y;
  endfunction

  // valid bits travel with the data
  logic [NumStages-1:0] vld_d, vld_q;

  // stage registers
  shares_t x_q, z_q, u_q, wr_q, v_q, m_q, y_q;
  shares_t z1_q, z2_q;
  rand_t rnd0_q, rnd1_q, rnd2_q;
  shares_t x_in, z_s1, u_d, w_s2, wr_d, v_d, m_d, y_d, aff_d;

  assign busy_o = 1'b0;

  always_comb begin
    for (int i = 0; i < Nsh; i++) begin
      x_in[i] = operand_i[8*i +: 8];
    end
    vld_d = {vld_q[NumStages-2:0], start_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: latch input
  always_ff @(posedge clk_i) begin
    x_q    <= x_in;
    rnd0_q <= {operand_i.rand_high, operand_i.rand_low};
  end

  // stage 2: z = x^2, refresh, u = zr * x
  always_comb begin
    for (int i = 0; i < Nsh; i++) z_s1[i] = mas_pkg::gf_sq(x_q[i]);
    u_d = isw(refresh(z_s1, rnd0_q, RzOff), x_q, rnd0_q, M1Off);
  end

  always_ff @(posedge clk_i) begin
    u_q    <= u_d;
    z_q    <= z_s1;
    rnd1_q <= rnd0_q;
  end

  // stage 3: w = u^4, refresh to wr, v = u * wr
  always_comb begin
    for (int i = 0; i < Nsh; i++) w_s2[i] = mas_pkg::gf_p4(u_q[i]);
    wr_d = refresh(w_s2, rnd1_q, RwOff);
    v_d  = isw(u_q, wr_d, rnd1_q, M2Off);
  end

  // v is computed in the same stage as wr (refresh is only xors)
  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    wr_q   <= wr_d;
    z1_q   <= z_q;
    rnd2_q <= rnd1_q;
  end

  // stage 4: m = v^16 * wr
  always_comb begin
    shares_t v16;
    for (int i = 0; i < Nsh; i++) v16[i] = mas_pkg::gf_p16(v_q[i]);
    m_d = isw(v16, wr_q, rnd2_q, M3Off);
  end

  rand_t rnd3_q;

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    z2_q   <= z1_q;
    rnd3_q <= rnd2_q;
  end

  // stage 5: y = m * z
  always_comb begin
    y_d = isw(m_q, z2_q, rnd3_q, M4Off);
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
  end

  // stage 6: affine map share by share
  always_comb begin
    for (int i = 0; i < Nsh; i++) aff_d[i] = mas_pkg::aff_map(y_q[i]);
    if ((MASK_ORDER % 2) == 1) aff_d[0] = aff_d[0] ^ mas_pkg::AffConst;
  end

  logic [2:0][7:0] out_d, out_q;

  // unused output shares stay zero
  always_comb begin
    out_d = '0;
    for (int i = 0; i < Nsh; i++) out_d[i] = aff_d[i];
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = vld_q[NumStages-1];
  assign result_o = mas_pkg::sbox_out_t'(out_q);

endmodule

// File: hw/rtl/mas_checker.sv
// port-level checker for the masked sbox and its bind
`include "masked_aes_sbox_macros.svh"

module mas_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o
);

  `MAS_ASSERT_IMPL(busy_never, clk_i, rst_ni, 1'b1, !busy_o)
  `MAS_ASSERT_IMPL(done_latency, clk_i, rst_ni, $past(start_i, 6) && $past(rst_ni, 6), done_o)
  `MAS_ASSERT_IMPL(no_spurious, clk_i, rst_ni, done_o, $past(start_i, 6))

endmodule

bind masked_aes_sbox mas_checker u_mas_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .done_o (done_o)
);

// File: bench/tb.sv
// testbench for the masked aes sbox: directed table plus random masked bytes
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaskOrder = 2;
  localparam int unsigned NumSh = MaskOrder + 1;
  localparam int unsigned NumRandom = 750;
  localparam int unsigned WatchLimit = 2000;
  localparam int unsigned DrainCycles = 12;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  mas_pkg::sbox_in_t  operand_i = '0;
  logic               done_o;
  mas_pkg::sbox_out_t result_o;

  masked_aes_sbox #(.MASK_ORDER(MaskOrder)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .operand_i(operand_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // expected output shares, oldest first
  mas_pkg::sbox_out_t sbox_expected_q[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  // field arithmetic of the predictor, written out here on its own
  function automatic logic [7:0] fmul(logic [7:0] p, logic [7:0] q);
    logic [8:0] a;
    logic [7:0] acc;
    acc = 8'h00;
    a = {1'b0, p};
    for (int k = 0; k < 8; k++) begin
      if (q[k]) acc ^= a[7:0];
      a = a << 1;
      if (a[8]) a ^= 9'h11b;
    end
    return acc;
  endfunction

  function automatic logic [7:0] fpow2n(logic [7:0] v, int n);
    logic [7:0] r;
    r = v;
    for (int k = 0; k < n; k++) r = fmul(r, r);
    return r;
  endfunction

  function automatic logic [7:0] affine(logic [7:0] v);
    logic [7:0] r;
    r = v ^ 8'h63;
    for (int k = 1; k <= 4; k++) r ^= (v << k) | (v >> (8 - k));
    return r;
  endfunction

  typedef logic [7:0] shares_t [NumSh];

  // masked multiply with pairwise random bytes taken from the pool
  function automatic void isw(input shares_t a, input shares_t b, output shares_t c,
                              input logic [127:0] pool, inout int pos);
    logic [7:0] r [NumSh][NumSh];
    for (int i = 0; i < NumSh; i++)
      for (int j = i + 1; j < NumSh; j++) begin
        r[i][j] = pool[8*pos +: 8];
        pos++;
        r[j][i] = r[i][j] ^ fmul(a[i], b[j]) ^ fmul(a[j], b[i]);
      end
    for (int i = 0; i < NumSh; i++) begin
      c[i] = fmul(a[i], b[i]);
      for (int j = 0; j < NumSh; j++)
        if (j != i) c[i] ^= r[i][j];
    end
  endfunction

  function automatic void remask(input shares_t x, output shares_t y,
                                 input logic [127:0] pool, inout int pos);
    y = x;
    for (int i = 1; i < NumSh; i++) begin
      y[0] ^= pool[8*pos +: 8];
      y[i] ^= pool[8*pos +: 8];
      pos++;
    end
  endfunction

  function automatic mas_pkg::sbox_out_t masked_sbox(mas_pkg::sbox_in_t op);
    shares_t x, z, zr, u, w, wr, v, v16, m, y;
    logic [127:0] pool;
    int pos;
    mas_pkg::sbox_out_t res;
    pool = {op.rand_high, op.rand_low};
    pos = 0;
    x[0] = op.share_in0;
    x[1] = op.share_in1;
    if (NumSh > 2) x[NumSh-1] = op.share_in2;
    for (int i = 0; i < NumSh; i++) z[i] = fpow2n(x[i], 1);
    remask(z, zr, pool, pos);
    isw(zr, x, u, pool, pos);
    for (int i = 0; i < NumSh; i++) w[i] = fpow2n(u[i], 2);
    remask(w, wr, pool, pos);
    isw(u, wr, v, pool, pos);
    for (int i = 0; i < NumSh; i++) v16[i] = fpow2n(v[i], 4);
    isw(v16, wr, m, pool, pos);
    isw(m, z, y, pool, pos);
    for (int i = 0; i < NumSh; i++) y[i] = affine(y[i]);
    if (MaskOrder % 2 == 1) y[0] ^= 8'h63;
    res = '0;
    res.share_out0 = y[0];
    res.share_out1 = y[1];
    if (NumSh > 2) res.share_out2 = y[NumSh-1];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch %s at %0t", msg, $time);
    error_count++;
  endtask

  // result side: the block shows each result for one cycle only
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (sbox_expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %06h", result_o));
      end else begin
        mas_pkg::sbox_out_t want;
        want = sbox_expected_q.pop_front();
        if (result_o.share_out0 !== want.share_out0)
          report_mismatch($sformatf("share_out0: got %02h want %02h",
                                    result_o.share_out0, want.share_out0));
        if (result_o.share_out1 !== want.share_out1)
          report_mismatch($sformatf("share_out1: got %02h want %02h",
                                    result_o.share_out1, want.share_out1));
        if (result_o.share_out2 !== want.share_out2)
          report_mismatch($sformatf("share_out2: got %02h want %02h",
                                    result_o.share_out2, want.share_out2));
      end
    end
  end

  // watchdog on cycles with no transaction in either direction
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // directed rows: 'have' marks an expectation typed in by hand
  typedef struct {
    mas_pkg::sbox_in_t  op;
    bit                 have;
    mas_pkg::sbox_out_t want;
  } sbox_row_t;

  sbox_row_t directed_rows[$];

  // present one transaction; start stays high between back to back items
  task automatic send_op(mas_pkg::sbox_in_t op, mas_pkg::sbox_out_t want);
    start_i <= 1'b1;
    operand_i <= op;
    do @(posedge clk_i); while (busy_o);
    sbox_expected_q.push_back(want);
  endtask

  function automatic mas_pkg::sbox_in_t rand_op();
    mas_pkg::sbox_in_t op;
    op.share_in0 = 8'($urandom);
    op.share_in1 = 8'($urandom);
    op.share_in2 = 8'($urandom);
    op.rand_low = {$urandom, $urandom};
    op.rand_high = {$urandom, $urandom};
    return op;
  endfunction

  initial begin
    sbox_row_t row;
    int burst;
    int unsigned sent;
    int drain;

    // zero shares and zero randomness: every share holds sbox(0)
    row.op = '0; row.have = 1'b1;
    row.want = '0; row.want.share_out0 = 8'h63;
    row.want.share_out1 = 8'h63; row.want.share_out2 = 8'h63;
    directed_rows.push_back(row);
    // all ones everywhere
    row.op = '1; row.have = 1'b0; directed_rows.push_back(row);
    // walking-bit shares: a single bit, its mirror and its complement
    for (int k = 0; k < 8; k++) begin
      row.op = '0; row.have = 1'b0;
      row.op.share_in0 = 8'h01 << k;
      row.op.share_in1 = 8'h80 >> k;
      row.op.share_in2 = 8'hff ^ (8'h01 << k);
      directed_rows.push_back(row);
    end
    // randomness extremes with each share alone at max
    for (int k = 0; k < 3; k++) begin
      row.op = '0; row.have = 1'b0;
      row.op.rand_low = '1;
      row.op.rand_high = (k == 1) ? 64'h0 : '1;
      case (k)
        0: row.op.share_in0 = 8'hff;
        1: row.op.share_in1 = 8'hff;
        default: row.op.share_in2 = 8'hff;
      endcase
      directed_rows.push_back(row);
    end
    // upper random bytes: only rand_high varies
    row.op = '0; row.have = 1'b0; row.op.share_in0 = 8'h53;
    row.op.rand_high = 64'ha5a5_5a5a_0f0f_f0f0;
    directed_rows.push_back(row);
    // shares that cancel to zero
    row.op = '0; row.have = 1'b0;
    row.op.share_in0 = 8'h3c; row.op.share_in1 = 8'h3c;
    row.op.rand_low = 64'h0123_4567_89ab_cdef;
    directed_rows.push_back(row);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      mas_pkg::sbox_out_t want;
      want = directed_rows[i].have ? directed_rows[i].want
                                   : masked_sbox(directed_rows[i].op);
      // the hand-typed row must agree with the predictor too
      if (directed_rows[i].have && want !== masked_sbox(directed_rows[i].op)) begin
        report_mismatch($sformatf("directed row %0d disagrees with the predictor", i));
      end
      send_op(directed_rows[i].op, want);
    end
    start_i <= 1'b0;

    // hold off until the pipeline has drained
    while (sbox_expected_q.size() != 0) @(posedge clk_i);

    // random part: bursts of back to back transactions with random gaps
    sent = 0;
    while (sent < NumRandom) begin
      mas_pkg::sbox_in_t op;
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < NumRandom; b++) begin
        op = rand_op();
        send_op(op, masked_sbox(op));
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 1'b0;
        operand_i <= rand_op();
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    start_i <= 1'b0;

    while (sbox_expected_q.size() != 0) @(posedge clk_i);
    drain = DrainCycles;
    repeat (drain) @(posedge clk_i);

    if (error_count == 0 && sbox_expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/mas_pkg.sv
hw/rtl/masked_aes_sbox.sv
hw/rtl/mas_checker.sv
bench/tb.sv
